[rtl/rmie_pkg.sv]
// Shared types and constants of the register machine instruction executor.
package rmie_pkg;

  // Operation codes; codes fourteen and fifteen carry no meaning and act as a no-op.
  typedef enum logic [3:0] {
    OP_LOAD = 4'd0,
    OP_MOVR = 4'd1,
    OP_DECR = 4'd2,
    OP_INCR = 4'd3,
    OP_NOPP = 4'd4,
    OP_ADDR = 4'd5,
    OP_SUBR = 4'd6,
    OP_MULR = 4'd7,
    OP_GOTO = 4'd8,
    OP_JMPZ = 4'd9,
    OP_JPNZ = 4'd10,
    OP_COMP = 4'd11,
    OP_DIVR = 4'd12,
    OP_MODR = 4'd13
  } op_t;

  // Instruction lengths in bytes.
  localparam logic [3:0] LEN_LOAD  = 4'd9;
  localparam logic [3:0] LEN_SHORT = 4'd5;
  localparam logic [3:0] LEN_NOPP  = 4'd4;
  localparam logic [3:0] LEN_TWO   = 4'd6;
  localparam logic [3:0] LEN_JUMP  = 4'd8;

  // Index of register A, the implicit target of COMP, DIVR and MODR.
  localparam logic [2:0] REG_A = 3'd0;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_EXEC,
    ST_ABS_A,
    ST_ABS_B,
    ST_ITER,
    ST_SIGN,
    ST_DONE
  } state_t;

  // One instruction.
  typedef struct packed {
    logic [3:0]         req_type;
    logic [2:0]         first_reg;
    logic [2:0]         second_reg;
    logic signed [31:0] immediate;
  } in_t;

  // One result.
  typedef struct packed {
    logic [31:0]        next_pc;
    logic signed [31:0] written_value;
    logic               branch_taken;
    logic               divide_by_zero;
  } out_t;

endpackage

[rtl/register_machine_instruction_executor_core.sv]
// Top level of the register machine instruction executor: sequencer, shared adder and registers.
//
// Usage: one decoded instruction is presented on the in_ channel (valid/ready) and one result
// transaction is returned on the out_ channel for every instruction. The code base register is
// written through the cfg_ channel, which is always ready; write it only while the block is idle.
// Instructions are executed strictly one at a time; in_ready is high only while the sequencer
// waits for the next instruction. Operands are read from a small register file memory in the
// read states RD1 and RD2, and all arithmetic runs through one 32-bit adder/subtractor under
// the sequencer. Single-step operations pass through EXEC and DONE; MULR iterates shift-and-add,
// one bit per cycle, and DIVR and MODR run two magnitude steps, 32 restoring steps and a sign
// fix-up before DONE; a zero divisor goes from EXEC straight to DONE, skipping the loop.
// With a ready receiver, DONE loads the result into the output register and offers it there.
// The result sits in that register; if the receiver stalls with an earlier result still held,
// the finished instruction waits in the final state, with its register write and PC update
// held back until the output register is free to take the new result.
// Reset (rst_n low, synchronous) clears the program counter, the code base, the valid bits that
// make every register read as zero, and the sequencer; no clearing pass is needed.
module register_machine_instruction_executor_core #(
  parameter int NUM_REGS = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmie_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rmie_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);
  import rmie_pkg::*;

  // The address width holds any operand index as well as the register count itself.
  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int CNT_W = $clog2(NUM_REGS + 1);
  localparam int AW    = (CNT_W > 3) ? CNT_W : 3;

  // Sequencer and datapath registers.
  state_t      state_r, state_nxt;
  in_t         req_r;
  logic [31:0] a_r, b_r, acc_r, res_r, npc_r, pc_r, code_base_r;
  logic [4:0]  cnt_r;
  logic        wr_en_r, taken_r, dz_r, neg_q_r, neg_rem_r;
  out_t        out_r;
  logic        out_valid_r;

  // Register file memory with per-entry valid bits.
  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [31:0]         rd_q_r;
  logic                rd_ok_r;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                rd_in_range, wr_in_range;
  logic [31:0]         rd_val;

  // Shared adder controls.
  logic [31:0] alu_a, alu_b, alu_sum;
  logic        alu_sub, alu_co;

  logic        in_fire, out_load, jmp_cond, ge_bit, is_div, writes_a;
  logic [31:0] div_shift, pc_inc, out_wv;
  logic [3:0]  len;
  op_t         op;

  assign op        = op_t'(req_r.req_type);
  assign in_fire   = in_valid && in_ready;
  assign is_div    = (op == OP_DIVR) || (op == OP_MODR);
  assign writes_a  = is_div || (op == OP_COMP);
  assign jmp_cond  = (a_r == 32'd0) == (op == OP_JMPZ);
  assign div_shift = {acc_r[30:0], a_r[31]};
  assign ge_bit    = alu_co;
  assign cfg_ready = 1'b1;

  // The one adder/subtractor that all arithmetic operations share.
  assign {alu_co, alu_sum} = {1'b0, alu_a} + {1'b0, alu_b ^ {32{alu_sub}}} + 33'(alu_sub);

  // Instruction length for the fall-through program counter.
  always_comb begin
    unique case (op)
      OP_LOAD:                   len = LEN_LOAD;
      OP_DECR, OP_INCR:          len = LEN_SHORT;
      OP_JMPZ, OP_JPNZ:          len = LEN_JUMP;
      OP_MOVR, OP_ADDR, OP_SUBR, OP_MULR,
      OP_COMP, OP_DIVR, OP_MODR: len = LEN_TWO;
      default:                   len = LEN_NOPP;
    endcase
  end
  assign pc_inc = pc_r + 32'(len);

  // Register file addressing; indices at or above NUM_REGS read as zero and drop writes.
  assign wr_addr     = writes_a ? AW'(REG_A) : AW'(req_r.first_reg);
  assign rd_in_range = rd_addr < AW'(NUM_REGS);
  assign wr_in_range = wr_addr < AW'(NUM_REGS);
  assign rd_val      = rd_ok_r ? rd_q_r : 32'd0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (op == OP_MULR) state_nxt = ST_ITER;
        else if (is_div && (b_r != 32'd0)) state_nxt = ST_ABS_A;
        else state_nxt = ST_DONE;
      end
      ST_ABS_A: state_nxt = ST_ABS_B;
      ST_ABS_B: state_nxt = ST_ITER;
      ST_ITER:  if (cnt_r == 5'd0) state_nxt = ST_SIGN;
      ST_SIGN:  state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes, read address and shared adder operands.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    rd_addr  = AW'(req_r.second_reg);
    alu_a    = a_r;
    alu_b    = b_r;
    alu_sub  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if ((op_t'(in_data.req_type) == OP_JMPZ) || (op_t'(in_data.req_type) == OP_JPNZ)) begin
          rd_addr = AW'(REG_A);
        end else begin
          rd_addr = AW'(in_data.first_reg);
        end
      end
      ST_EXEC: begin
        unique case (op)
          OP_LOAD: alu_b = req_r.immediate;
          OP_DECR: begin
            alu_b   = 32'd1;
            alu_sub = 1'b1;
          end
          OP_INCR: alu_b = 32'd1;
          OP_SUBR, OP_COMP: alu_sub = 1'b1;
          OP_GOTO: alu_b = code_base_r;
          OP_JMPZ, OP_JPNZ: begin
            alu_a = req_r.immediate;
            alu_b = code_base_r;
          end
          default: ;
        endcase
      end
      ST_ABS_A: begin
        alu_a   = 32'd0;
        alu_b   = a_r;
        alu_sub = 1'b1;
      end
      ST_ABS_B: begin
        alu_a   = 32'd0;
        alu_sub = 1'b1;
      end
      ST_ITER: begin
        if (op == OP_MULR) begin
          alu_a = acc_r;
          alu_b = b_r[0] ? a_r : 32'd0;
        end else begin
          alu_a   = div_shift;
          alu_sub = 1'b1;
        end
      end
      ST_SIGN: begin
        alu_a   = 32'd0;
        alu_b   = (op == OP_DIVR) ? a_r : acc_r;
        alu_sub = 1'b1;
      end
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Sequencer state and architectural control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= 32'd0;
      code_base_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) code_base_r <= cfg_data;
      if (out_load) begin
        pc_r        <= npc_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, loaded step by step under the sequencer.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (in_fire) req_r <= in_data;
      ST_RD1:  a_r <= rd_val;
      ST_RD2:  b_r <= rd_val;
      ST_EXEC: begin
        npc_r   <= pc_inc;
        taken_r <= 1'b0;
        dz_r    <= 1'b0;
        wr_en_r <= 1'b0;
        res_r   <= 32'd0;
        acc_r   <= 32'd0;
        cnt_r   <= 5'd31;
        neg_q_r   <= a_r[31] ^ b_r[31];
        neg_rem_r <= a_r[31];
        unique case (op)
          OP_LOAD, OP_DECR, OP_INCR, OP_ADDR, OP_SUBR: begin
            res_r   <= alu_sum;
            wr_en_r <= 1'b1;
          end
          OP_MOVR: begin
            res_r   <= b_r;
            wr_en_r <= 1'b1;
          end
          OP_COMP: begin
            res_r   <= 32'(alu_sum == 32'd0);
            wr_en_r <= 1'b1;
          end
          OP_GOTO: begin
            npc_r   <= alu_sum;
            taken_r <= 1'b1;
          end
          OP_JMPZ, OP_JPNZ: begin
            if (jmp_cond) begin
              npc_r   <= alu_sum;
              taken_r <= 1'b1;
            end
          end
          OP_DIVR, OP_MODR: dz_r <= (b_r == 32'd0);
          default: ;
        endcase
      end
      ST_ABS_A: if (a_r[31]) a_r <= alu_sum;
      ST_ABS_B: if (b_r[31]) b_r <= alu_sum;
      ST_ITER: begin
        cnt_r <= cnt_r - 5'd1;
        if (op == OP_MULR) begin
          acc_r <= alu_sum;
          a_r   <= {a_r[30:0], 1'b0};
          b_r   <= {1'b0, b_r[31:1]};
        end else begin
          acc_r <= ge_bit ? alu_sum : div_shift;
          a_r   <= {a_r[30:0], ge_bit};
        end
      end
      ST_SIGN: begin
        wr_en_r <= 1'b1;
        if (op == OP_MULR) res_r <= acc_r;
        else if (op == OP_DIVR) res_r <= neg_q_r ? alu_sum : a_r;
        else res_r <= neg_rem_r ? alu_sum : acc_r;
      end
      default: ;
    endcase
  end

  // Register file: one write port at retirement, one registered read port.
  always_ff @(posedge clk) begin
    if (out_load && wr_en_r && wr_in_range) mem[wr_addr[IDX_W-1:0]] <= res_r;
    rd_q_r  <= mem[rd_addr[IDX_W-1:0]];
    rd_ok_r <= rd_in_range && vld_r[rd_addr[IDX_W-1:0]];
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (out_load && wr_en_r && wr_in_range) begin
      vld_r[wr_addr[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Result register.
  assign out_wv = (wr_en_r && wr_in_range) ? res_r : 32'd0;
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.next_pc        <= npc_r;
      out_r.written_value  <= out_wv;
      out_r.branch_taken   <= taken_r;
      out_r.divide_by_zero <= dz_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // An accepted instruction closes the input until its result has been produced.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("instruction accepted while another was in flight");

  // A zero divisor never writes a register.
  a_dz_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_by_zero) |-> (out_data.written_value == 32'sd0))
    else $error("divide by zero reported with a written value");

  // A result is never both a taken branch and a division fault.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.branch_taken && out_data.divide_by_zero))
    else $error("branch and divide-by-zero flagged together");

  // The program counter moves only when a result is handed to the output register.
  a_pc_at_retire: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DONE) |=> $stable(pc_r))
    else $error("program counter changed outside retirement");

endmodule

[sim/rmie_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the register machine instruction executor: predicts and compares results.
module rmie_result_checker #(
  parameter int NUM_REGS = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  rmie_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  rmie_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [31:0]    cfg_data,
  output int             fail_count,
  output int             pending_count
);
  import rmie_pkg::*;

  // Shadow copy of the architectural state and the code base register.
  logic [31:0] shadow_regs [NUM_REGS];
  logic [31:0] shadow_pc;
  logic [31:0] shadow_code_base;

  // Results predicted for accepted instructions, oldest first.
  out_t expected_results [$];
  int   mismatch_total = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // A register beyond the implemented ones reads as zero.
  function automatic logic [31:0] read_shadow_reg(logic [2:0] idx);
    if (idx < NUM_REGS) return shadow_regs[idx];
    return '0;
  endfunction

  // Returns the value now held, or zero when the write falls outside the file.
  function automatic logic [31:0] write_shadow_reg(logic [2:0] idx, logic [31:0] value);
    if (idx < NUM_REGS) begin
      shadow_regs[idx] = value;
      return value;
    end
    return '0;
  endfunction

  function automatic logic [31:0] magnitude(logic [31:0] value);
    return value[31] ? 32'(-value) : value;
  endfunction

  // Signed division truncating toward zero; the remainder follows the dividend's sign.
  function automatic logic [31:0] signed_quotient(logic [31:0] dividend, logic [31:0] divisor);
    logic [31:0] quot;
    quot = magnitude(dividend) / magnitude(divisor);
    return (dividend[31] ^ divisor[31]) ? 32'(-quot) : quot;
  endfunction

  function automatic logic [31:0] signed_remainder(logic [31:0] dividend, logic [31:0] divisor);
    logic [31:0] rem;
    rem = magnitude(dividend) % magnitude(divisor);
    return dividend[31] ? 32'(-rem) : rem;
  endfunction

  // Executes one instruction on the shadow state and returns the result it must produce.
  function automatic out_t execute_instruction(in_t ins);
    out_t        res;
    logic [31:0] src1;
    logic [31:0] src2;
    logic [31:0] pc;
    logic [31:0] written;
    logic        taken;
    logic        div_zero;
    src1     = read_shadow_reg(ins.first_reg);
    src2     = read_shadow_reg(ins.second_reg);
    pc       = shadow_pc;
    written  = '0;
    taken    = 1'b0;
    div_zero = 1'b0;
    case (ins.req_type)
      OP_LOAD: begin
        written = write_shadow_reg(ins.first_reg, src1 + ins.immediate);
        pc      = pc + LEN_LOAD;
      end
      OP_MOVR: begin
        written = write_shadow_reg(ins.first_reg, src2);
        pc      = pc + LEN_TWO;
      end
      OP_DECR: begin
        written = write_shadow_reg(ins.first_reg, src1 - 32'd1);
        pc      = pc + LEN_SHORT;
      end
      OP_INCR: begin
        written = write_shadow_reg(ins.first_reg, src1 + 32'd1);
        pc      = pc + LEN_SHORT;
      end
      OP_ADDR: begin
        written = write_shadow_reg(ins.first_reg, src1 + src2);
        pc      = pc + LEN_TWO;
      end
      OP_SUBR: begin
        written = write_shadow_reg(ins.first_reg, src1 - src2);
        pc      = pc + LEN_TWO;
      end
      OP_MULR: begin
        written = write_shadow_reg(ins.first_reg, src1 * src2);
        pc      = pc + LEN_TWO;
      end
      OP_GOTO: begin
        pc    = src1 + shadow_code_base;
        taken = 1'b1;
      end
      OP_JMPZ, OP_JPNZ: begin
        if ((read_shadow_reg(REG_A) == '0) == (ins.req_type == OP_JMPZ)) begin
          pc    = ins.immediate + shadow_code_base;
          taken = 1'b1;
        end else begin
          pc = pc + LEN_JUMP;
        end
      end
      OP_COMP: begin
        written = write_shadow_reg(REG_A, (src1 == src2) ? 32'd1 : 32'd0);
        pc      = pc + LEN_TWO;
      end
      OP_DIVR, OP_MODR: begin
        if (src2 == '0) begin
          div_zero = 1'b1;
        end else if (ins.req_type == OP_DIVR) begin
          written = write_shadow_reg(REG_A, signed_quotient(src1, src2));
        end else begin
          written = write_shadow_reg(REG_A, signed_remainder(src1, src2));
        end
        pc = pc + LEN_TWO;
      end
      default: begin
        pc = pc + LEN_NOPP;
      end
    endcase
    shadow_pc          = pc;
    res.next_pc        = pc;
    res.written_value  = written;
    res.branch_taken   = taken;
    res.divide_by_zero = div_zero;
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      mismatch_total++;
    end
  endfunction

  // Watch all three channels; results are compared before the same edge's instruction is
  // predicted, since a result always belongs to an earlier transaction.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
      shadow_pc        = '0;
      shadow_code_base = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no instruction outstanding, expected none, got %h",
                   $time, out_data);
          mismatch_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("next_pc", want.next_pc, out_data.next_pc);
          check_field("written_value", want.written_value, out_data.written_value);
          check_field("branch_taken", 32'(want.branch_taken), 32'(out_data.branch_taken));
          check_field("divide_by_zero", 32'(want.divide_by_zero), 32'(out_data.divide_by_zero));
        end
      end
      if (cfg_valid && cfg_ready) shadow_code_base = cfg_data;
      if (in_valid && in_ready) expected_results.push_back(execute_instruction(in_data));
    end
    pending_count <= expected_results.size();
    fail_count    <= mismatch_total;
  end

endmodule

[sim/tb_register_machine_instruction_executor_core.sv]
`timescale 1ns / 100ps
// Testbench top for the register machine instruction executor: stimulus, pacing and verdict.
module tb_register_machine_instruction_executor_core;
  import rmie_pkg::*;

  // Codes with no operation behind them; the block treats them as a no-op.
  localparam logic [3:0] OP_SPARE_LO = 4'd14;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_E = 3'd4;
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam logic [2:0] REG_SIX  = 3'd6;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_count;

  // Pacing shared between the sender and the receiver process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  register_machine_instruction_executor_core #(
    .NUM_REGS (5)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rmie_result_checker #(
    .NUM_REGS (5)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Receiver: random back-pressure, with a long hold-off whenever the stimulus asks for one.
  initial begin
    int stall_served;
    int stall_left;
    stall_served = 0;
    stall_left   = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request != stall_served) begin
        stall_served = stall_request;
        stall_left   = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_t make_instr(logic [3:0] op, logic [2:0] r1, logic [2:0] r2,
                                     logic [31:0] imm);
    in_t ins;
    ins.req_type   = op;
    ins.first_reg  = r1;
    ins.second_reg = r2;
    ins.immediate  = imm;
    return ins;
  endfunction

  // Mostly valid register names, now and then one beyond the file.
  function automatic logic [2:0] random_reg();
    if ($urandom_range(15) == 0) return 3'($urandom_range(7, 5));
    return 3'($urandom_range(4));
  endfunction

  // Small immediates keep operands near zero so that zero tests and small divisors occur often.
  function automatic logic [31:0] random_immediate();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return 32'($urandom_range(20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_instruction();
    int          pick;
    logic [3:0]  op;
    pick = $urandom_range(99);
    if      (pick < 22) op = OP_LOAD;
    else if (pick < 30) op = OP_MOVR;
    else if (pick < 35) op = OP_DECR;
    else if (pick < 40) op = OP_INCR;
    else if (pick < 43) op = OP_NOPP;
    else if (pick < 50) op = OP_ADDR;
    else if (pick < 57) op = OP_SUBR;
    else if (pick < 63) op = OP_MULR;
    else if (pick < 67) op = OP_GOTO;
    else if (pick < 73) op = OP_JMPZ;
    else if (pick < 79) op = OP_JPNZ;
    else if (pick < 86) op = OP_COMP;
    else if (pick < 93) op = OP_DIVR;
    else if (pick < 98) op = OP_MODR;
    else if (pick < 99) op = OP_SPARE_LO;
    else                op = OP_SPARE_HI;
    return make_instr(op, random_reg(), random_reg(), random_immediate());
  endfunction

  // Offer one instruction, with random idle cycles first, and return at its acceptance edge.
  task automatic send_instruction(input in_t ins);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every outstanding result transaction has been taken.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_code_base(input logic [31:0] base);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int count, input int s_pct, input int r_pct,
                                  input int stall_at);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      if (n == stall_at) stall_request++;
      send_instruction(random_instruction());
    end
    wait_results_drained();
  endtask

  // Directed opening: field extremes, wrap-around, every operation and the corner cases.
  task automatic run_directed();
    in_t directed_list [$];
    send_idle_pct = 11;
    recv_idle_pct = 70;
    directed_list = '{
      make_instr(OP_LOAD, REG_A, REG_A, 32'h7FFF_FFFF),
      make_instr(OP_LOAD, REG_B, REG_A, 32'h8000_0000),
      make_instr(OP_LOAD, REG_C, REG_A, 32'hFFFF_FFFF),
      // Writes beyond the register file are dropped.
      make_instr(OP_LOAD, REG_NONE, REG_NONE, 32'd5),
      make_instr(OP_INCR, REG_NONE, REG_A, 32'd0),
      make_instr(OP_INCR, REG_A, REG_A, 32'd0),
      // Minimum divided by minus one wraps; its remainder is zero.
      make_instr(OP_DIVR, REG_A, REG_C, 32'd0),
      make_instr(OP_MODR, REG_A, REG_C, 32'd0),
      make_instr(OP_JMPZ, REG_A, REG_A, 32'h0000_0100),
      make_instr(OP_JPNZ, REG_A, REG_A, 32'h0000_0200),
      // Zero divisors, the second read from beyond the register file.
      make_instr(OP_DIVR, REG_B, REG_D, 32'd0),
      make_instr(OP_MODR, REG_B, REG_SIX, 32'd0),
      make_instr(OP_MOVR, REG_D, REG_C, 32'd0),
      make_instr(OP_MOVR, REG_E, REG_B, 32'd0),
      make_instr(OP_ADDR, REG_D, REG_E, 32'd0),
      make_instr(OP_SUBR, REG_E, REG_D, 32'd0),
      make_instr(OP_MULR, REG_D, REG_D, 32'd0),
      make_instr(OP_DECR, REG_C, REG_A, 32'd0),
      make_instr(OP_LOAD, REG_C, REG_A, 32'hFFFF_FFF9),
      // Negative dividend with a divisor of one; the remainder comes out zero.
      make_instr(OP_MODR, REG_C, REG_E, 32'd0),
      make_instr(OP_COMP, REG_D, REG_E, 32'd0),
      make_instr(OP_JPNZ, REG_A, REG_A, 32'hFFFF_FFF0),
      make_instr(OP_JMPZ, REG_A, REG_A, 32'h0000_0040),
      make_instr(OP_GOTO, REG_B, REG_A, 32'd0),
      make_instr(OP_NOPP, REG_A, REG_A, 32'd0),
      make_instr(OP_SPARE_LO, REG_A, REG_A, 32'd0),
      make_instr(OP_SPARE_HI, REG_A, REG_A, 32'd0)
    };
    foreach (directed_list[i]) send_instruction(directed_list[i]);
    wait_results_drained();
  endtask

  // Main stimulus and verdict.
  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_code_base(32'h0000_0000);
    run_directed();
    write_code_base(32'hFFFF_FFFF);
    run_random_phase(145, 11, 70, -1);
    write_code_base($urandom);
    run_random_phase(145, 70, 11, -1);
    write_code_base(32'h8000_0000);
    // No idling here, apart from one long receiver hold-off to back the block up.
    run_random_phase(145, 0, 0, 30);

    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
